// ===== hw/rtl/base10000_numeric_to_scaled_decimal_top_defines.svh =====
// Assertion macros shared by the converter RTL.
// Included by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef BASE10000_NUMERIC_TO_SCALED_DECIMAL_TOP_DEFINES_SVH
`define BASE10000_NUMERIC_TO_SCALED_DECIMAL_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BNSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BNSD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define BNSD_ASSERT(label, prop, msg)
`define BNSD_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== hw/rtl/bnsd_pkg.sv =====
// Shared types, constants and constant functions of the scaled decimal converter.
// No dependencies; used by the front end, the back end and the top level.
`timescale 1ns / 1ps
package bnsd_pkg;

    localparam int MAX_DIGITS  = 40;
    localparam int MAX_WIDTH   = 38;
    localparam int QUEUE_DEPTH = 2;

    // Header kind codes (bits 15:14 of the header word).
    localparam logic [1:0] KIND_POS   = 2'b00;
    localparam logic [1:0] KIND_NEG   = 2'b01;
    localparam logic [1:0] KIND_SHORT = 2'b10;
    localparam logic [1:0] KIND_NAN   = 2'b11;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAC_SCALE = 2'd0;
    localparam logic [1:0] CFG_DEC_WIDTH  = 2'd1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EXCESS = 2'd1,
        ST_RANGE  = 2'd2,
        ST_NAN    = 2'd3
    } status_t;

    // Reciprocals for exact division of a 14-bit digit by 10, 100 and 1000.
    localparam int          RECIP_SHIFT = 24;
    localparam logic [20:0] RECIP10     = 21'd1677722;
    localparam logic [20:0] RECIP100    = 21'd167773;
    localparam logic [20:0] RECIP1000   = 21'd16778;

    // One queued work step, produced per input beat.
    typedef struct packed {
        logic        scale;
        logic [2:0]  k;
        logic [13:0] add;
        logic [13:0] dig;
        logic [1:0]  ridx;
        logic        chk_rem;
        logic        nz_exc;
        logic        last;
        logic        fin_do;
        logic [17:0] fin_k;
        logic        nan;
        logic        cnt_bad;
        logic        neg;
    } bnsd_op_t;

    // Evaluated at elaboration only.
    function automatic logic [127:0] pow10_const(input int e);
        logic [127:0] v;
        int k;
        v = 128'd1;
        for (k = 0; k < e; k++)
        begin
            v = v * 128'd10;
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/bnsd_front.sv =====
// Front end: decodes the header, tracks the digit position and classifies each digit.
// Depends on bnsd_pkg; feeds bnsd_queue.
`timescale 1ns / 1ps
module bnsd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [5:0]         frac_scale,
    input  logic               push,
    input  logic [15:0]        header_word,
    input  logic [15:0]        long_weight,
    input  logic [5:0]         digit_count,
    input  logic [13:0]        digit,
    input  logic               last_digit,
    output bnsd_pkg::bnsd_op_t op
);

    logic [5:0]         idx_reg;
    logic [5:0]         idx_next;
    logic [1:0]         kind;
    logic               is_short;
    logic signed [15:0] w;
    logic signed [17:0] nm1w;
    logic signed [19:0] drop0;
    logic [17:0]        dq;
    logic [5:0]         keep;
    logic [1:0]         r;
    logic [17:0]        pad;
    logic [19:0]        neg_drop;
    logic [34:0]        prod;
    logic [13:0]        quot;
    logic [20:0]        recip;
    logic [5:0]         gap;
    logic [8:0]         rem;

    assign kind     = header_word[15:14];
    assign is_short = (kind == bnsd_pkg::KIND_SHORT);
    assign w        = is_short ? {{9{header_word[6]}}, header_word[6:0]} : long_weight;
    assign nm1w     = $signed({12'd0, digit_count}) - 18'sd1 - $signed({{2{w[15]}}, w});
    assign drop0    = $signed({nm1w, 2'b00}) - $signed({14'd0, frac_scale});
    assign dq       = drop0[19:2];
    assign neg_drop = 20'd0 - drop0;
    assign idx_next = (idx_reg == 6'd63) ? idx_reg : idx_reg + 6'd1;

    always_comb
    begin
        keep = 6'd0;
        r    = 2'd0;
        pad  = 18'd0;
        if (digit_count != 6'd0)
        begin
            if (!drop0[19])
            begin
                if (dq < {12'd0, digit_count})
                begin
                    keep = digit_count - dq[5:0];
                    r    = drop0[1:0];
                end
            end
            else
            begin
                keep = digit_count;
                pad  = neg_drop[17:0];
            end
        end
    end

    // Digit divided by 10^r through a reciprocal multiply; the quotient fits in 11 bits.
    always_comb
    begin
        case (r)
            2'd1:    recip = bnsd_pkg::RECIP10;
            2'd2:    recip = bnsd_pkg::RECIP100;
            default: recip = bnsd_pkg::RECIP1000;
        endcase
    end
    assign prod = {21'd0, digit} * {14'd0, recip};
    assign quot = (r == 2'd0) ? digit : {3'd0, prod[bnsd_pkg::RECIP_SHIFT +: 11]};

    // Scale steps still owed after the last beat when it comes early.
    assign gap = keep - 6'd1 - idx_next;
    assign rem = (idx_next < keep) ? ({1'b0, gap, 2'b00} + {6'd0, 3'd4 - {1'b0, r}}) : 9'd0;

    always_comb
    begin
        op         = '0;
        op.dig     = digit;
        op.ridx    = r;
        op.last    = last_digit;
        op.fin_do  = (keep != 6'd0);
        op.fin_k   = pad + {9'd0, rem};
        op.nan     = (kind == bnsd_pkg::KIND_NAN);
        op.cnt_bad = ({26'd0, digit_count} > 32'(bnsd_pkg::MAX_DIGITS));
        op.neg     = is_short ? header_word[13] : (kind == bnsd_pkg::KIND_NEG);
        if (idx_reg < digit_count)
        begin
            if (idx_reg >= keep)
            begin
                op.nz_exc = (digit != 14'd0);
            end
            else if (idx_reg == keep - 6'd1)
            begin
                op.scale   = 1'b1;
                op.chk_rem = (r != 2'd0);
                op.k       = 3'd4 - {1'b0, r};
                op.add     = quot;
            end
            else
            begin
                op.scale = 1'b1;
                op.k     = 3'd4;
                op.add   = digit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 6'd0;
        end
        else if (push)
        begin
            idx_reg <= last_digit ? 6'd0 : idx_next;
        end
    end

endmodule

// ===== hw/rtl/bnsd_queue.sv =====
// Short queue of work steps between the front end and the back end.
// Depends on the assertion header; generic in width and depth.
`timescale 1ns / 1ps
`include "base10000_numeric_to_scaled_decimal_top_defines.svh"
module bnsd_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    `BNSD_ASSERT(a_no_push_full, !(push && full), "queue written while full")
    `BNSD_ASSERT(a_no_pop_empty, !(pop && empty), "queue read while empty")
    `BNSD_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "queue count out of range")

endmodule

// ===== hw/rtl/bnsd_back.sv =====
// Back end: accumulates the 128-bit magnitude, applies scaling and builds the result.
// Depends on bnsd_pkg and the assertion header; reads work steps from bnsd_queue.
`timescale 1ns / 1ps
`include "base10000_numeric_to_scaled_decimal_top_defines.svh"
module bnsd_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [5:0]         dec_width,
    input  bnsd_pkg::bnsd_op_t q_data,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata,
    output logic [1:0]         m_tuser
);

    typedef enum logic [5:0] {
        S_POP   = 6'b000001,
        S_SCALE = 6'b000010,
        S_ADD   = 6'b000100,
        S_CHK   = 6'b001000,
        S_LAST  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    logic [127:0] pow_tab [0:bnsd_pkg::MAX_WIDTH];

    for (genvar g = 0; g <= bnsd_pkg::MAX_WIDTH; g++)
    begin : g_pow
        assign pow_tab[g] = bnsd_pkg::pow10_const(g);
    end

    state_t             state_reg, state_next;
    bnsd_pkg::bnsd_op_t op_reg, op_next;
    logic [127:0]       acc_reg, acc_next;
    logic [17:0]        cnt_reg, cnt_next;
    logic [13:0]        add_reg, add_next;
    logic               exc_reg, exc_next;
    logic               ovf_reg, ovf_next;
    logic               fin_reg, fin_next;
    logic               ovalid_reg, ovalid_next;
    logic [127:0]       odata_reg, odata_next;
    logic [1:0]         ouser_reg, ouser_next;

    logic [23:0]        qp;
    logic               rem_nz;
    logic [5:0]         wsel;
    logic               out_free;
    bnsd_pkg::status_t  status;
    logic [127:0]       acc_neg;

    // Quotient times the divisor, to see whether a dropped part was nonzero.
    always_comb
    begin
        case (q_data.ridx)
            2'd1:    qp = ({10'd0, q_data.add} << 3) + ({10'd0, q_data.add} << 1);
            2'd2:    qp = ({10'd0, q_data.add} << 6) + ({10'd0, q_data.add} << 5)
                          + ({10'd0, q_data.add} << 2);
            2'd3:    qp = ({10'd0, q_data.add} << 10) - ({10'd0, q_data.add} << 4)
                          - ({10'd0, q_data.add} << 3);
            default: qp = {10'd0, q_data.add};
        endcase
    end
    assign rem_nz = q_data.chk_rem && (qp != {10'd0, q_data.dig});

    assign wsel     = (dec_width > 6'(bnsd_pkg::MAX_WIDTH)) ? 6'(bnsd_pkg::MAX_WIDTH) : dec_width;
    assign out_free = !ovalid_reg || m_tready;
    assign acc_neg  = ~acc_reg + 128'd1;
    assign q_pop    = (state_reg == S_POP) && !q_empty;

    always_comb
    begin
        if (op_reg.nan)
        begin
            status = bnsd_pkg::ST_NAN;
        end
        else if (op_reg.cnt_bad)
        begin
            status = bnsd_pkg::ST_RANGE;
        end
        else if (exc_reg)
        begin
            status = bnsd_pkg::ST_EXCESS;
        end
        else if (ovf_reg || acc_reg >= pow_tab[wsel])
        begin
            status = bnsd_pkg::ST_RANGE;
        end
        else
        begin
            status = bnsd_pkg::ST_OK;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        add_next    = add_reg;
        exc_next    = exc_reg;
        ovf_next    = ovf_reg;
        fin_next    = fin_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        ouser_next  = ouser_reg;
        unique case (state_reg)
            S_POP:
            begin
                if (!q_empty)
                begin
                    op_next  = q_data;
                    exc_next = exc_reg | q_data.nz_exc | rem_nz;
                    if (q_data.scale && !ovf_reg)
                    begin
                        cnt_next   = {15'd0, q_data.k};
                        add_next   = q_data.add;
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        state_next = S_LAST;
                    end
                end
            end
            S_SCALE:
            begin
                if (cnt_reg != 18'd0 && acc_reg != 128'd0)
                begin
                    if (acc_reg >= pow_tab[bnsd_pkg::MAX_WIDTH - 1])
                    begin
                        // Once sticky overflow is set the pending add is abandoned.
                        ovf_next   = 1'b1;
                        state_next = fin_reg ? S_FIN : S_LAST;
                    end
                    else
                    begin
                        acc_next = (acc_reg << 3) + (acc_reg << 1);
                        cnt_next = cnt_reg - 18'd1;
                    end
                end
                else
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                acc_next   = acc_reg + {114'd0, add_reg};
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (acc_reg >= pow_tab[bnsd_pkg::MAX_WIDTH])
                begin
                    ovf_next = 1'b1;
                end
                state_next = fin_reg ? S_FIN : S_LAST;
            end
            S_LAST:
            begin
                if (!op_reg.last)
                begin
                    state_next = S_POP;
                end
                else if (op_reg.fin_do && !ovf_reg)
                begin
                    cnt_next   = op_reg.fin_k;
                    add_next   = 14'd0;
                    fin_next   = 1'b1;
                    state_next = S_SCALE;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ouser_next  = status;
                    if (status != bnsd_pkg::ST_OK)
                    begin
                        odata_next = 128'd0;
                    end
                    else
                    begin
                        odata_next = op_reg.neg ? acc_neg : acc_reg;
                    end
                    acc_next   = 128'd0;
                    exc_next   = 1'b0;
                    ovf_next   = 1'b0;
                    fin_next   = 1'b0;
                    state_next = S_POP;
                end
            end
            default:
            begin
                state_next = S_POP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_POP;
            acc_reg    <= 128'd0;
            exc_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            fin_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            exc_reg    <= exc_next;
            ovf_reg    <= ovf_next;
            fin_reg    <= fin_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        cnt_reg   <= cnt_next;
        add_reg   <= add_next;
        odata_reg <= odata_next;
        ouser_reg <= ouser_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;

    `BNSD_ASSERT(a_err_zero, !(ovalid_reg && ouser_reg != bnsd_pkg::ST_OK) || odata_reg == 128'd0,
        "failed result carries a nonzero value")
    `BNSD_ASSERT_NEXT(a_scale_done, state_reg == S_SCALE && cnt_reg == 18'd0,
        state_reg == S_ADD, "scaling did not move on to the add")
    `BNSD_ASSERT_NEXT(a_fin_clear, state_reg == S_FIN && out_free,
        acc_reg == 128'd0 && !ovf_reg && !exc_reg, "accumulator not cleared after a result")

endmodule

// ===== hw/rtl/base10000_numeric_to_scaled_decimal_top.sv =====
// Top level of the base-10000 to scaled 128-bit decimal converter.
// Depends on bnsd_pkg, bnsd_front, bnsd_queue and bnsd_back.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake           Content
// s_        in         s_tvalid/s_tready   one digit beat, tlast ends the value
// m_        out        m_tvalid/m_tready   scaled value in tdata, status in tuser
// cfg_      in         cfg_valid/cfg_ready register index and write data
//
// The front end takes a beat each cycle while the step queue has room.
// Per digit the back end pops a step, runs up to four multiply-by-ten steps and an
// exit step, an add and a range check, then a decision; an unscaled digit goes from
// the pop straight to the decision. The final beat adds the missing scale steps,
// which stop on overflow, and loads the output register. Reset clears the queue,
// the accumulator and output valid at once; a stalled output holds the back end.
module base10000_numeric_to_scaled_decimal_top
#(
    parameter int QUEUE_DEPTH = bnsd_pkg::QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,   // header_word[15:0], long_weight[31:16],
                                    // digit_count[37:32], digit[51:38], zero pad
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // value_low[63:0], value_high[127:64]
    output logic [1:0]   m_tuser,   // status[1:0]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [5:0]   cfg_data
);

    logic               frac_scale_reg;
    logic [5:0]         frac_reg;
    logic [5:0]         width_reg;
    logic               push;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    bnsd_pkg::bnsd_op_t f_op;
    bnsd_pkg::bnsd_op_t q_op;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign push      = s_tvalid && s_tready;

    // Config registers; also marks that the scale register has been written at least once since reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frac_reg       <= 6'd0;
            width_reg      <= 6'(bnsd_pkg::MAX_WIDTH);
            frac_scale_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bnsd_pkg::CFG_FRAC_SCALE:
                begin
                    frac_reg       <= cfg_data;
                    frac_scale_reg <= 1'b1;
                end
                bnsd_pkg::CFG_DEC_WIDTH:
                begin
                    width_reg <= cfg_data;
                end
                default:
                begin
                    frac_scale_reg <= frac_scale_reg;
                end
            endcase
        end
    end

    bnsd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frac_scale  (frac_scale_reg ? frac_reg : 6'd0),
        .push        (push),
        .header_word (s_tdata[15:0]),
        .long_weight (s_tdata[31:16]),
        .digit_count (s_tdata[37:32]),
        .digit       (s_tdata[51:38]),
        .last_digit  (s_tlast),
        .op          (f_op)
    );

    bnsd_queue
    #(
        .WIDTH ($bits(bnsd_pkg::bnsd_op_t)),
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (f_op),
        .pop     (q_pop),
        .rd_data (q_op),
        .full    (q_full),
        .empty   (q_empty)
    );

    bnsd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_width (width_reg),
        .q_data    (q_op),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
